>>> design/otwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwc_pkg
// Shared constants and types of the overlapping token window chunker.
// ----------------------------------------------------------------------------
package otwc_pkg;

  localparam int unsigned TOKEN_W       = 16;
  localparam int unsigned LINE_W        = 6;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned MAX_LINES_DEF = 64;

  localparam logic [TOKEN_W-1:0] TARGET_RESET  = TOKEN_W'(512);
  localparam logic [TOKEN_W-1:0] OVERLAP_RESET = TOKEN_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = CFG_IDX_W'(1);

  typedef struct packed {
    logic [TOKEN_W-1:0] target;
    logic [TOKEN_W-1:0] overlap;
  } cfg_t;

endpackage

>>> design/otwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otwc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/otwc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwc_cfg
// Configuration registers: window target and overlap budgets.
// ----------------------------------------------------------------------------
module otwc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [otwc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [otwc_pkg::TOKEN_W-1:0]     cfg_wdata_i,
  output otwc_pkg::cfg_t                   cfg_o
);

  otwc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otwc_pkg::REG_TARGET:  cfg_d.target  = cfg_wdata_i;
        otwc_pkg::REG_OVERLAP: cfg_d.overlap = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target  <= otwc_pkg::TARGET_RESET;
      cfg_q.overlap <= otwc_pkg::OVERLAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/otwc_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwc_walk
// Line loader and window walker over the line store, with the result register.
// ----------------------------------------------------------------------------
module otwc_walk #(
  parameter int unsigned MAX_LINES = otwc_pkg::MAX_LINES_DEF,
  localparam int unsigned IW       = $clog2(MAX_LINES + 1),
  localparam int unsigned AW       = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  otwc_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [otwc_pkg::TOKEN_W-1:0]  line_token_count_i,
  input  logic                          final_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [otwc_pkg::LINE_W-1:0]   window_first_line_o,
  output logic [otwc_pkg::LINE_W-1:0]   window_last_line_o,
  output logic [otwc_pkg::TOKEN_W-1:0]  window_token_total_o,
  output logic                          final_window_o,
  output logic                          lines_dropped_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [otwc_pkg::TOKEN_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [otwc_pkg::TOKEN_W-1:0]  ram_rdata_i
);

  localparam int unsigned TW = otwc_pkg::TOKEN_W;
  localparam int unsigned LW = otwc_pkg::LINE_W;

  typedef enum logic [2:0] {
    ST_LOAD, ST_FREQ, ST_FCHK, ST_PUT, ST_BREQ, ST_BCHK
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] n_q, n_d, start_q, start_d, end_q, end_d, back_q, back_d;
  logic [TW-1:0] sum_q, sum_d, osum_q, osum_d;
  logic          ovf_q, ovf_d;
  logic          ov_q, ov_d;
  logic [LW-1:0] first_q, first_d, last_q, last_d;
  logic [TW-1:0] total_q, total_d;
  logic          fin_q, fin_d, drop_q, drop_d;

  logic          in_acc, out_free, is_last;
  logic [IW-1:0] end_inc, end_m1, back_m1, start_inc;
  logic [TW:0]   sum_ext, osum_ext, tgt_ext, ovl_ext;
  logic [TW-1:0] tok;

  assign in_acc    = in_valid_i && (state_q == ST_LOAD);
  assign out_free  = !ov_q || !out_stall_i;
  assign end_inc   = end_q + IW'(1);
  assign end_m1    = end_q - IW'(1);
  assign back_m1   = back_q - IW'(1);
  assign start_inc = start_q + IW'(1);
  assign is_last   = (end_q >= n_q);
  assign sum_ext   = {1'b0, sum_q} + {1'b0, ram_rdata_i};
  assign osum_ext  = {1'b0, osum_q} + {1'b0, ram_rdata_i};
  assign tgt_ext   = (cfg_i.target == '0) ? (TW + 1)'(1) : {1'b0, cfg_i.target};
  assign ovl_ext   = {1'b0, cfg_i.overlap};
  assign tok       = (line_token_count_i == '0) ? TW'(1) : line_token_count_i;

  assign ram_we_o    = in_acc && (n_q != IW'(MAX_LINES));
  assign ram_waddr_o = n_q[AW-1:0];
  assign ram_wdata_o = tok;
  assign ram_raddr_o = (state_q == ST_BREQ) ? back_m1[AW-1:0] : end_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    start_d = start_q;
    end_d   = end_q;
    back_d  = back_q;
    sum_d   = sum_q;
    osum_d  = osum_q;
    ovf_d   = ovf_q;
    ov_d    = ov_q;
    first_d = first_q;
    last_d  = last_q;
    total_d = total_q;
    fin_d   = fin_q;
    drop_d  = drop_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (n_q != IW'(MAX_LINES)) begin
            n_d = n_q + IW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (final_line_i) begin
            start_d = '0;
            end_d   = '0;
            sum_d   = '0;
            state_d = ST_FREQ;
          end
        end
      end
      ST_FREQ: state_d = ST_FCHK;
      ST_FCHK: begin
        if ((end_q != start_q) && (sum_ext > tgt_ext)) begin
          state_d = ST_PUT;
        end else begin
          sum_d = sum_ext[TW-1:0];
          end_d = end_inc;
          if ((sum_ext >= tgt_ext) || (end_inc >= n_q)) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_FREQ;
          end
        end
      end
      ST_PUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          first_d = LW'(start_q);
          last_d  = LW'(end_m1);
          total_d = sum_q;
          fin_d   = is_last;
          drop_d  = ovf_q;
          if (is_last) begin
            n_d     = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            back_d  = end_q;
            osum_d  = '0;
            state_d = ST_BREQ;
          end
        end
      end
      ST_BREQ: begin
        if (back_q > start_q) begin
          state_d = ST_BCHK;
        end else begin
          start_d = start_inc;
          end_d   = start_inc;
          sum_d   = '0;
          state_d = ST_FREQ;
        end
      end
      ST_BCHK: begin
        if (osum_ext > ovl_ext) begin
          start_d = back_q;
          end_d   = back_q;
          sum_d   = '0;
          state_d = ST_FREQ;
        end else begin
          osum_d  = osum_ext[TW-1:0];
          back_d  = back_m1;
          state_d = ST_BREQ;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    back_q  <= back_d;
    sum_q   <= sum_d;
    osum_q  <= osum_d;
    first_q <= first_d;
    last_q  <= last_d;
    total_q <= total_d;
    fin_q   <= fin_d;
    drop_q  <= drop_d;
  end

  assign in_stall_o           = (state_q != ST_LOAD);
  assign out_valid_o          = ov_q;
  assign window_first_line_o  = first_q;
  assign window_last_line_o   = last_q;
  assign window_token_total_o = total_q;
  assign final_window_o       = fin_q;
  assign lines_dropped_o      = drop_q;

endmodule

>>> design/overlapping_token_window_chunker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlapping_token_window_chunker_top
// Stores per-line token counts and, after the last line, cuts them into
// overlapping windows of whole lines, one result word per window.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid_i/in_stall_o| line_token_count_i, final_line_i
//   out     | out_valid_o/out_stall_i | window_first_line_o, window_last_line_o,
//           |                      | window_token_total_o, final_window_o,
//           |                      | lines_dropped_o
//   cfg     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// A line word is taken every cycle while loading. After the final line the
// walk reads lines forward (ST_FREQ, ST_FCHK) and back for the overlap (ST_BREQ,
// ST_BCHK), request then check as the store read is registered; ST_PUT emits
// each window, and a window whose lines all fit the overlap adds an ST_BREQ.
// The store is not cleared at reset; only lines loaded in the run are read.
// A stalled result holds; the walk keeps going until the next window is due.
// ----------------------------------------------------------------------------
module overlapping_token_window_chunker_top #(
  parameter int unsigned MAX_LINES = otwc_pkg::MAX_LINES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [otwc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [otwc_pkg::TOKEN_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [otwc_pkg::TOKEN_W-1:0]     line_token_count_i,
  input  logic                             final_line_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [otwc_pkg::LINE_W-1:0]      window_first_line_o,
  output logic [otwc_pkg::LINE_W-1:0]      window_last_line_o,
  output logic [otwc_pkg::TOKEN_W-1:0]     window_token_total_o,
  output logic                             final_window_o,
  output logic                             lines_dropped_o
);

  localparam int unsigned AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  otwc_pkg::cfg_t                cfg;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [otwc_pkg::TOKEN_W-1:0]  ram_wdata, ram_rdata;

  otwc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  otwc_ram #(
    .WIDTH (otwc_pkg::TOKEN_W),
    .DEPTH (MAX_LINES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  otwc_walk #(
    .MAX_LINES (MAX_LINES)
  ) u_walk (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .line_token_count_i   (line_token_count_i),
    .final_line_i         (final_line_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .window_first_line_o  (window_first_line_o),
    .window_last_line_o   (window_last_line_o),
    .window_token_total_o (window_token_total_o),
    .final_window_o       (final_window_o),
    .lines_dropped_o      (lines_dropped_o),
    .ram_we_o             (ram_we),
    .ram_waddr_o          (ram_waddr),
    .ram_wdata_o          (ram_wdata),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata)
  );

  a_final_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_line_i |=> in_stall_o)
    else $error("walk did not start after final line");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_first_line_o <= window_last_line_o)
    else $error("window ends before it starts");

  a_window_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_token_total_o != '0)
    else $error("empty window total");

endmodule
